>>> design/sti_pkg.sv
// Shared types and constants for the sorted table insert/merge block.
package sti_pkg;

	localparam int KEY_BITS      = 10;
	localparam int DEPTH_DEFAULT = 64;
	localparam int CODE_BITS     = 8;
	localparam int POS_BITS      = 6;
	localparam int COUNT_BITS    = 7;

	typedef enum logic [2:0] {
		ST_INSERTED   = 3'd0,
		ST_MERGED     = 3'd1,
		ST_FULL       = 3'd2,
		ST_READ_OK    = 3'd3,
		ST_READ_RANGE = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		FN_INSERT = 1'b0,
		FN_READ   = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PROBE,
		S_CMP,
		S_MATCH,
		S_PLACE,
		S_SHIFT,
		S_SHLAST,
		S_INS,
		S_RREQ,
		S_RDATA,
		S_OUT
	} state_t;

	typedef struct packed {
		func_t                 func;
		logic [KEY_BITS-1:0]   key_id;
		logic [CODE_BITS-1:0]  level_code;
		logic [CODE_BITS-1:0]  tag_code;
		logic [POS_BITS-1:0]   read_pos;
	} in_t;

	typedef struct packed {
		status_t                status;
		logic [POS_BITS-1:0]    entry_pos;
		logic [KEY_BITS-1:0]    entry_key;
		logic [CODE_BITS-1:0]   entry_level;
		logic [CODE_BITS-1:0]   entry_tag;
		logic [COUNT_BITS-1:0]  entry_count;
	} out_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [CODE_BITS-1:0]  level;
		logic [CODE_BITS-1:0]  tag;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

endpackage

>>> design/sti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/sorted_table_insert_or_merge.sv
// Top level: sorted key table with binary-search insert/merge and positional read.
// Insert: a binary search of probe/compare steps, a key check that merges on a match,
//   then a shift of the later entries up by one and the write of the new entry (a full
//   table gives a full status instead); then the output register is loaded, back to idle.
// Read: a RAM read of the given position, or a range status when it is out of range.
//   One item at a time; all steps share the single RAM port pair.
// A finished result waits in an output register while the next item is taken.
// Reset clears the entry count and control state; table contents are not cleared.
module sorted_table_insert_or_merge
	import sti_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int DW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t          state_q, state_d;
	in_t             req_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   lo_q, hi_q;
	logic [DW-1:0]   idx_q, wa_q;
	logic            pend_q;
	out_t            res_q, out_q;
	logic            out_valid_q;

	logic            ram_we;
	logic [DW-1:0]   ram_waddr, ram_raddr;
	entry_t          ram_wdata, rd_entry;
	logic [ENTRY_BITS-1:0] ram_rdata;

	logic [CW-1:0]   mid, cnt_inc;
	logic            key_less, key_eq, rpos_ok, full;
	logic [CODE_BITS-1:0] mrg_level, mrg_tag;

	sti_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_entry  = ram_rdata;
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign cnt_inc   = count_q + CW'(1);
	assign key_less  = rd_entry.key < req_q.key_id;
	assign key_eq    = rd_entry.key == req_q.key_id;
	assign rpos_ok   = {{CW{1'b0}}, req_q.read_pos} < {{POS_BITS{1'b0}}, count_q};
	assign full      = count_q == CW'(TABLE_DEPTH);
	assign mrg_level = (req_q.level_code != '0) ? req_q.level_code : rd_entry.level;
	assign mrg_tag   = (req_q.tag_code != '0) ? req_q.tag_code : rd_entry.tag;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.func == FN_READ) ? S_RREQ : S_PROBE;
				end
			end
			S_PROBE: begin
				if (lo_q < hi_q) begin
					state_d = S_CMP;
				end else if (lo_q < count_q) begin
					state_d = S_MATCH;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_CMP:    state_d = S_PROBE;
			S_MATCH:  state_d = key_eq ? S_OUT : S_PLACE;
			S_PLACE: begin
				if (full) begin
					state_d = S_OUT;
				end else if (count_q == lo_q) begin
					state_d = S_INS;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (idx_q == DW'(lo_q)) begin
					state_d = S_SHLAST;
				end
			end
			S_SHLAST: state_d = S_INS;
			S_INS:    state_d = S_OUT;
			S_RREQ:   state_d = rpos_ok ? S_RDATA : S_OUT;
			S_RDATA:  state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = DW'(lo_q);
		ram_wdata = rd_entry;
		ram_raddr = DW'(mid);
		case (state_q)
			S_PROBE: begin
				ram_raddr = (lo_q < hi_q) ? DW'(mid) : DW'(lo_q);
			end
			S_MATCH: begin
				ram_we    = key_eq;
				ram_wdata = '{key: rd_entry.key, level: mrg_level, tag: mrg_tag};
			end
			S_SHIFT: begin
				ram_raddr = idx_q;
				ram_we    = pend_q;
				ram_waddr = wa_q;
			end
			S_SHLAST: begin
				ram_we    = 1'b1;
				ram_waddr = wa_q;
			end
			S_INS: begin
				ram_we    = 1'b1;
				ram_wdata = '{key: req_q.key_id, level: req_q.level_code,
					tag: req_q.tag_code};
			end
			S_RREQ:   ram_raddr = DW'(req_q.read_pos);
			default:  ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_PLACE:  pend_q <= 1'b0;
				S_SHIFT:  pend_q <= 1'b1;
				S_INS:    count_q <= cnt_inc;
				default:  pend_q <= pend_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= in_data;
				lo_q  <= '0;
				hi_q  <= count_q;
			end
			S_CMP: begin
				if (key_less) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
			end
			S_MATCH: begin
				res_q <= '{status: ST_MERGED, entry_pos: POS_BITS'(lo_q),
					entry_key: rd_entry.key, entry_level: mrg_level,
					entry_tag: mrg_tag, entry_count: COUNT_BITS'(count_q)};
			end
			S_PLACE: begin
				idx_q <= DW'(count_q - CW'(1));
				res_q <= '{status: ST_FULL, entry_pos: '0, entry_key: req_q.key_id,
					entry_level: '0, entry_tag: '0, entry_count: COUNT_BITS'(count_q)};
			end
			S_SHIFT: begin
				wa_q  <= idx_q + DW'(1);
				idx_q <= idx_q - DW'(1);
			end
			S_INS: begin
				res_q <= '{status: ST_INSERTED, entry_pos: POS_BITS'(lo_q),
					entry_key: req_q.key_id, entry_level: req_q.level_code,
					entry_tag: req_q.tag_code, entry_count: COUNT_BITS'(cnt_inc)};
			end
			S_RREQ: begin
				res_q <= '{status: ST_READ_RANGE, entry_pos: '0, entry_key: '0,
					entry_level: '0, entry_tag: '0, entry_count: COUNT_BITS'(count_q)};
			end
			S_RDATA: begin
				res_q <= '{status: ST_READ_OK, entry_pos: req_q.read_pos,
					entry_key: rd_entry.key, entry_level: rd_entry.level,
					entry_tag: rd_entry.tag, entry_count: COUNT_BITS'(count_q)};
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q <= res_q;
				end
			end
			default: begin
				req_q <= req_q;
			end
		endcase
	end

endmodule
